@@ rtl/core/ring_buffer_with_push_front_macros.svh @@
// assertion macros for the ring buffer with push to head
`ifndef RING_BUFFER_WITH_PUSH_FRONT_MACROS_SVH
`define RING_BUFFER_WITH_PUSH_FRONT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RBPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbpf: same-cycle check failed");
// next-cycle implication
`define RBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbpf: next-cycle check failed");
`else
`define RBPF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/rbpf_pkg.sv @@
// shared types and codes of the ring buffer with push to head
package rbpf_pkg;

    // width of counts, capacity and threshold
    localparam int CNT_W = 5;

    // capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // action codes
    localparam logic [1:0] ACT_PUSH_TAIL = 2'd0;
    localparam logic [1:0] ACT_PUSH_HEAD = 2'd1;
    localparam logic [1:0] ACT_POP       = 2'd2;
    localparam logic [1:0] ACT_QUERY     = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result fields other than the data word
    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] occupancy;
        logic             reached;
        logic             empty_res;
    } res_t;

endpackage

@@ rtl/core/ring_buffer_with_push_front.sv @@
// top level of the ring buffer with push to head and pop at head
// an item taken at edge N executes in the next cycle; its result is registered and
// done is high for one cycle after that
// busy is high while an item executes, and no new item is taken until busy is low
// the receiver cannot stall; a new item may be taken in the cycle done is high
// reset clears indices and count and sets capacity to 16; slot contents are not cleared
module ring_buffer_with_push_front #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 action,
    input  logic [DATA_WIDTH-1:0]      data_in,
    input  logic [rbpf_pkg::CNT_W-1:0] threshold,
    input  logic                       cfg_we,
    input  logic [rbpf_pkg::CNT_W-1:0] cfg_data,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [DATA_WIDTH-1:0]      data_out,
    output logic [rbpf_pkg::CNT_W-1:0] occupancy,
    output logic                       reached,
    output logic                       empty_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  res_valid;
    rbpf_pkg::res_t        res;
    logic [DATA_WIDTH-1:0] res_data;

    logic                  done_reg;
    rbpf_pkg::res_t        res_reg;
    logic [DATA_WIDTH-1:0] data_out_reg;

    // slot store
    rbpf_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // control
    rbpf_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .data_in   (data_in),
        .threshold (threshold),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_data  (res_data)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg      <= res;
            data_out_reg <= res_data;
        end
    end

    assign done      = done_reg;
    assign status    = res_reg.status;
    assign occupancy = res_reg.occupancy;
    assign reached   = res_reg.reached;
    assign empty_res = res_reg.empty_res;
    assign data_out  = data_out_reg;

endmodule

@@ rtl/core/rbpf_mem.sv @@
// slot store: one write port, one read port with registered read data
module rbpf_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]                  wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]                  rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rbpf_ctrl.sv @@
// index, count and capacity control; reads and updates the slot store
`include "ring_buffer_with_push_front_macros.svh"

module rbpf_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             action,
    input  logic [DATA_WIDTH-1:0]                  data_in,
    input  logic [rbpf_pkg::CNT_W-1:0]             threshold,
    input  logic                                   cfg_we,
    input  logic [rbpf_pkg::CNT_W-1:0]             cfg_data,
    output logic                                   mem_we,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
    output logic [DATA_WIDTH-1:0]                  mem_wdata,
    output logic                                   mem_re,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
    input  logic [DATA_WIDTH-1:0]                  mem_rdata,
    output logic                                   res_valid,
    output rbpf_pkg::res_t                         res,
    output logic [DATA_WIDTH-1:0]                  res_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = rbpf_pkg::CNT_W;
    // compare width covering both index and count
    localparam int IW = ((AW > CW) ? AW : CW) + 1;

    logic                  exec_reg;
    logic [CW-1:0]         cap_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [1:0]            act_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [CW-1:0]         thr_reg;

    logic                  accept;
    logic [CW-1:0]         cap_eff;
    logic                  full;
    logic [AW-1:0]         tail_n, head_n;
    logic [AW-1:0]         tail_inc, head_inc, head_dec;
    logic [1:0]            status_c;
    logic [DATA_WIDTH-1:0] data_c;

    assign accept = start && !exec_reg;
    assign busy   = exec_reg;

    // effective capacity: zero acts as one, clipped to the built depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // wrapped indices and their neighbors
    always_comb
    begin
        tail_n   = (IW'(tail_reg) >= IW'(cap_eff)) ? '0 : tail_reg;
        head_n   = (IW'(head_reg) >= IW'(cap_eff)) ? '0 : head_reg;
        tail_inc = ((IW'(tail_n) + IW'(1)) >= IW'(cap_eff)) ? '0 : tail_n + AW'(1);
        head_inc = ((IW'(head_n) + IW'(1)) >= IW'(cap_eff)) ? '0 : head_n + AW'(1);
        head_dec = (head_n == '0) ? AW'(cap_eff - CW'(1)) : head_n - AW'(1);
        full     = (count_reg >= cap_eff);
    end

    // read at the head when an item is taken; the previous item's write
    // completed at the end of its own execute cycle, so no forwarding
    assign mem_re    = accept;
    assign mem_raddr = head_n;
    assign mem_wdata = data_reg;

    // execute: decode the action against the current state
    always_comb
    begin
        status_c   = rbpf_pkg::ST_DONE;
        data_c     = '0;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        mem_we     = 1'b0;
        mem_waddr  = tail_n;
        if (exec_reg)
        begin
            unique case (act_reg)
                rbpf_pkg::ACT_PUSH_TAIL:
                begin
                    if (full)
                    begin
                        status_c = rbpf_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = tail_n;
                        tail_next  = tail_inc;
                        count_next = count_reg + CW'(1);
                    end
                end
                rbpf_pkg::ACT_PUSH_HEAD:
                begin
                    if (full)
                    begin
                        status_c = rbpf_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                rbpf_pkg::ACT_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_c = rbpf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_c     = mem_rdata;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                rbpf_pkg::ACT_QUERY:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // result of the item in execute
    assign res_valid     = exec_reg;
    assign res.status    = status_c;
    assign res.occupancy = count_next;
    assign res.reached   = (count_next >= thr_reg);
    assign res.empty_res = (count_next == '0);
    assign res_data      = data_c;

    // control state; a capacity write empties the buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg  <= 1'b0;
            cap_reg   <= rbpf_pkg::CAP_RESET;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            exec_reg <= accept;
            if (cfg_we)
            begin
                cap_reg   <= cfg_data;
                count_reg <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
            end
        end
    end

    // item fields held for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            data_reg <= data_in;
            thr_reg  <= threshold;
        end
    end

    // checks
    `RBPF_ASSERT_IMPL(a_count_in_cap, clk, rst_n, 1'b1, count_reg <= cap_eff)
    `RBPF_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, exec_reg)
    `RBPF_ASSERT_NEXT(a_exec_one_cycle, clk, rst_n, exec_reg, !exec_reg)
    `RBPF_ASSERT_NEXT(a_cfg_empties, clk, rst_n, cfg_we, count_reg == '0)
    `RBPF_ASSERT_NEXT(a_pop_decrements, clk, rst_n, exec_reg && !cfg_we && (act_reg == rbpf_pkg::ACT_POP) && (count_reg != '0), count_reg == $past(count_reg) - CW'(1))

endmodule
